/* design/sri_pkg.sv */
// shared types, constants and step functions for the sellmeier index pipeline
package sri_pkg;

  localparam int LAM_W  = 24;
  localparam int SQ_W   = 2 * LAM_W;
  localparam int COEF_W = 32;
  localparam int CSH    = 18;
  localparam int DM_W   = COEF_W + CSH;
  localparam int PROD_W = COEF_W + LAM_W;
  localparam int NUM_W  = COEF_W + SQ_W;
  localparam int DIV_N  = 60;
  localparam int NHI_W  = NUM_W - DIV_N;
  localparam int RAD_W  = 64;
  localparam int RT_N   = 32;
  localparam int RT_REM_W = RT_N + 2;
  localparam int NTERM  = 3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_POLE = 2'd1;
  localparam logic [1:0] ST_NEG  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [2:0] REG_B_FIRST  = 3'd0;
  localparam logic [2:0] REG_B_SECOND = 3'd1;
  localparam logic [2:0] REG_B_THIRD  = 3'd2;
  localparam logic [2:0] REG_C_FIRST  = 3'd3;
  localparam logic [2:0] REG_C_SECOND = 3'd4;
  localparam logic [2:0] REG_C_THIRD  = 3'd5;

  typedef struct packed {
    logic [DM_W-1:0]  rem;
    logic [DIV_N-1:0] word;   // dividend bits shift out the top, quotient bits in below
    logic [DM_W-1:0]  dm;
    logic             neg;
    logic             sat;
  } div_t;

  typedef struct packed {
    logic [RT_REM_W-1:0] rem;
    logic [RT_N-1:0]     root;
    logic [2*RT_N-1:0]   x;
  } rt_t;

  function automatic div_t div_step(input div_t d);
    logic [DM_W:0] rem_sh;
    logic [DM_W:0] diff;
    logic          ge;
    div_t          n;
    rem_sh = {d.rem, d.word[DIV_N-1]};
    ge     = rem_sh >= {1'b0, d.dm};
    diff   = rem_sh - {1'b0, d.dm};
    n      = d;
    n.rem  = ge ? diff[DM_W-1:0] : rem_sh[DM_W-1:0];
    n.word = {d.word[DIV_N-2:0], ge};
    return n;
  endfunction

  function automatic rt_t rt_step(input rt_t r);
    logic [RT_REM_W+1:0] rem_sh;
    logic [RT_REM_W+1:0] trial;
    logic                ge;
    rt_t                 n;
    rem_sh = {r.rem, r.x[2*RT_N-1:2*RT_N-2]};
    trial  = {2'b00, r.root, 2'b01};
    ge     = rem_sh >= trial;
    n.rem  = ge ? RT_REM_W'(rem_sh - trial) : rem_sh[RT_REM_W-1:0];
    n.root = {r.root[RT_N-2:0], ge};
    n.x    = {r.x[2*RT_N-3:0], 2'b00};
    return n;
  endfunction

  // signed term value, magnitude clamped at 2^60
  function automatic logic signed [RAD_W-1:0] term_val(input div_t d);
    logic [RAD_W-1:0] mag;
    mag = d.sat ? (RAD_W'(1) << DIV_N) : RAD_W'(d.word);
    return d.neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

/* design/sellmeier_refractive_index.sv */
// three-term sellmeier refractive index, fully pipelined
// usage:
//   input channel: a request is taken at a clock edge with start high and busy low;
//   busy is always low, so a new wavelength may enter on every cycle.
//   result channel: out_valid is high for one cycle with out_index_value and
//   out_status; the receiver cannot stall, so no backpressure exists.
//   config channel: cfg_valid/cfg_ready with cfg_index 0..5 (b1,b2,b3,c1,c2,c3)
//   and cfg_data; cfg_ready is always high, indexes above 5 are dropped.
//   write coefficients only while no request is in flight.
// depth: set by the 60-stage restoring divider (one quotient bit per stage, three
//   terms in parallel) and the 32-stage square root.
// throughput: one wavelength per cycle.
// reset: synchronous active-low rst_n clears all stage valid bits and the
//   coefficient registers to zero; results in flight are dropped.
// status: 0 ok, 1 pole (index 0), 2 negative radicand (index 0),
//   3 overflow (index all ones).
module sellmeier_refractive_index (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [sri_pkg::LAM_W-1:0] in_wavelength_um,
  output logic                      out_valid,
  output logic [31:0]               out_index_value,
  output logic [1:0]                out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import sri_pkg::*;

  logic [COEF_W-1:0] b_r [NTERM];
  logic [COEF_W-1:0] c_r [NTERM];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NTERM; t++) begin
        b_r[t] <= '0;
        c_r[t] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B_FIRST:  b_r[0] <= cfg_data;
        REG_B_SECOND: b_r[1] <= cfg_data;
        REG_B_THIRD:  b_r[2] <= cfg_data;
        REG_C_FIRST:  c_r[0] <= cfg_data;
        REG_C_SECOND: c_r[1] <= cfg_data;
        REG_C_THIRD:  c_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // front stages
  logic              lam_vld_r, sq_vld_r, prod_vld_r, num_vld_r, sum_vld_r;
  logic [LAM_W-1:0]  lam_r;
  logic [SQ_W-1:0]   sq_r;
  logic [PROD_W-1:0] plo_r [NTERM];
  logic [PROD_W-1:0] phi_r [NTERM];
  logic [DM_W-1:0]   dm_r [NTERM];
  logic [DM_W-1:0]   dmn_r [NTERM];
  logic              neg_r [NTERM];
  logic              negn_r [NTERM];
  logic [NUM_W-1:0]  num_r [NTERM];
  logic              pole_r, polen_r;

  div_t              div_r [DIV_N+1][NTERM];
  logic [DIV_N:0]    div_vld_r;
  logic [DIV_N:0]    div_pole_r;

  logic signed [RAD_W-1:0] rad_r;
  logic                    sum_pole_r;

  rt_t               rt_r [RT_N+1];
  logic [RT_N:0]     rt_vld_r;
  logic [1:0]        rt_st_r [RT_N+1];

  logic              out_valid_r;
  logic [31:0]       out_index_r;
  logic [1:0]        out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_vld_r   <= 1'b0;
      sq_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      num_vld_r   <= 1'b0;
      div_vld_r   <= '0;
      sum_vld_r   <= 1'b0;
      rt_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lam_vld_r   <= start && !busy;
      sq_vld_r    <= lam_vld_r;
      prod_vld_r  <= sq_vld_r;
      num_vld_r   <= prod_vld_r;
      div_vld_r   <= {div_vld_r[DIV_N-1:0], num_vld_r};
      sum_vld_r   <= div_vld_r[DIV_N];
      rt_vld_r    <= {rt_vld_r[RT_N-1:0], sum_vld_r};
      out_valid_r <= rt_vld_r[RT_N];
    end
  end

  always_ff @(posedge clk) begin
    logic [DM_W-1:0] cs;
    logic [COEF_W-1:0] bm;
    logic bneg, dneg;
    logic pole;
    lam_r <= in_wavelength_um;
    sq_r  <= SQ_W'(lam_r) * SQ_W'(lam_r);
    pole = 1'b0;
    for (int t = 0; t < NTERM; t++) begin
      cs   = {c_r[t], {CSH{1'b0}}};
      bneg = b_r[t][COEF_W-1];
      bm   = bneg ? (~b_r[t] + COEF_W'(1)) : b_r[t];
      dneg = DM_W'(sq_r) < cs;
      plo_r[t] <= PROD_W'(bm) * PROD_W'(sq_r[LAM_W-1:0]);
      phi_r[t] <= PROD_W'(bm) * PROD_W'(sq_r[SQ_W-1:LAM_W]);
      dm_r[t]  <= dneg ? (cs - DM_W'(sq_r)) : (DM_W'(sq_r) - cs);
      neg_r[t] <= bneg != dneg;
      if (DM_W'(sq_r) == cs) pole = 1'b1;
      // build the full product, hold divisor alongside
      num_r[t]  <= {phi_r[t], {LAM_W{1'b0}}} + NUM_W'(plo_r[t]);
      dmn_r[t]  <= dm_r[t];
      negn_r[t] <= neg_r[t];
      // quotient of 2^60 or more saturates
      div_r[0][t].sat  <= DM_W'(num_r[t][NUM_W-1:DIV_N]) >= dmn_r[t];
      div_r[0][t].rem  <= DM_W'(num_r[t][NUM_W-1:DIV_N]);
      div_r[0][t].word <= num_r[t][DIV_N-1:0];
      div_r[0][t].dm   <= dmn_r[t];
      div_r[0][t].neg  <= negn_r[t];
    end
    pole_r        <= pole;
    polen_r       <= pole_r;
    div_pole_r[0] <= polen_r;
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    always_ff @(posedge clk) begin
      for (int t = 0; t < NTERM; t++) div_r[k+1][t] <= div_step(div_r[k][t]);
      div_pole_r[k+1] <= div_pole_r[k];
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= RAD_W'(64'sd1 <<< 28) + term_val(div_r[DIV_N][0])
           + term_val(div_r[DIV_N][1]) + term_val(div_r[DIV_N][2]);
    sum_pole_r <= div_pole_r[DIV_N];
    rt_r[0].rem  <= '0;
    rt_r[0].root <= '0;
    rt_r[0].x    <= {rad_r[35:0], 28'd0};
    if (sum_pole_r)                            rt_st_r[0] <= ST_POLE;
    else if (rad_r < 0)                        rt_st_r[0] <= ST_NEG;
    else if (rad_r >= (RAD_W'(64'sd1 <<< 36))) rt_st_r[0] <= ST_OVF;
    else                                       rt_st_r[0] <= ST_OK;
  end

  for (genvar k = 0; k < RT_N; k++) begin : g_rt
    always_ff @(posedge clk) begin
      rt_r[k+1]    <= rt_step(rt_r[k]);
      rt_st_r[k+1] <= rt_st_r[k];
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= rt_st_r[RT_N];
    case (rt_st_r[RT_N])
      ST_OK:   out_index_r <= rt_r[RT_N].root;
      ST_OVF:  out_index_r <= '1;
      default: out_index_r <= '0;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_index_value = out_index_r;
  assign out_status      = out_status_r;

  a_pole_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_POLE || out_status_r == ST_NEG)
      |-> out_index_r == '0)
    else $error("pole or negative radicand with nonzero index");

  a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OVF |-> out_index_r == '1)
    else $error("overflow without saturated index");

  a_vld_chain: assert property (@(posedge clk) disable iff (!rst_n)
    rt_vld_r[0] |-> $past(sum_vld_r))
    else $error("root stage valid without sum stage");

endmodule
